// File: hdl/ats_pkg.sv
package ats_pkg;

	localparam int ROW_BITS = 16;
	localparam int COLUMN_BITS = 16;
	localparam int OFFSET_BITS = 24;
	localparam int KEYWORD_MAX_LEN = 5;
	localparam int PREFIX_BITS = 8 * KEYWORD_MAX_LEN;
	localparam int LEN_BITS = 16;
	localparam int NUM_KEYWORDS = 42;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [5:0] KIND_EOF = 6'd0;
	localparam logic [5:0] KIND_STRING = 6'd1;
	localparam logic [5:0] KIND_NUMBER = 6'd2;
	localparam logic [5:0] KIND_IDENT = 6'd3;
	localparam logic [5:0] KIND_COMMA = 6'd4;
	localparam logic [5:0] KIND_COLON = 6'd5;
	localparam logic [5:0] KIND_KEYWORD0 = 6'd6;
	localparam logic [5:0] KIND_BAD = 6'd48;
	localparam logic [5:0] KIND_UNCLOSED = 6'd49;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_COMMENT,
		MODE_STRING,
		MODE_NUMBER,
		MODE_WORD
	} mode_t;

	typedef struct packed {
		logic [5:0] kind;
		logic [ROW_BITS-1:0] row;
		logic [COLUMN_BITS-1:0] column;
		logic [OFFSET_BITS-1:0] offset;
		logic [LEN_BITS-1:0] length;
		logic [31:0] number;
		logic [7:0] bad;
		logic last;
	} token_t;

	// keyword spelling, right aligned, with its length
	typedef struct packed {
		logic [PREFIX_BITS-1:0] text;
		logic [3:0] len;
	} keyword_t;

	function automatic keyword_t kw_entry(input int idx);
		keyword_t k;
		k.text = '0;
		k.len = 4'd0;
		case (idx)
			0: begin k.text = PREFIX_BITS'("LD"); k.len = 4'd2; end
			1: begin k.text = PREFIX_BITS'("ST"); k.len = 4'd2; end
			2: begin k.text = PREFIX_BITS'("LDB"); k.len = 4'd3; end
			3: begin k.text = PREFIX_BITS'("STB"); k.len = 4'd3; end
			4: begin k.text = PREFIX_BITS'("LDR"); k.len = 4'd3; end
			5: begin k.text = PREFIX_BITS'("STR"); k.len = 4'd3; end
			6: begin k.text = PREFIX_BITS'("LBR"); k.len = 4'd3; end
			7: begin k.text = PREFIX_BITS'("SBR"); k.len = 4'd3; end
			8: begin k.text = PREFIX_BITS'("LDI"); k.len = 4'd3; end
			9: begin k.text = PREFIX_BITS'("CMP"); k.len = 4'd3; end
			10: begin k.text = PREFIX_BITS'("MOV"); k.len = 4'd3; end
			11: begin k.text = PREFIX_BITS'("ADD"); k.len = 4'd3; end
			12: begin k.text = PREFIX_BITS'("SUB"); k.len = 4'd3; end
			13: begin k.text = PREFIX_BITS'("MUL"); k.len = 4'd3; end
			14: begin k.text = PREFIX_BITS'("DIV"); k.len = 4'd3; end
			15: begin k.text = PREFIX_BITS'("AND"); k.len = 4'd3; end
			16: begin k.text = PREFIX_BITS'("OR"); k.len = 4'd2; end
			17: begin k.text = PREFIX_BITS'("XOR"); k.len = 4'd3; end
			18: begin k.text = PREFIX_BITS'("ADDI"); k.len = 4'd4; end
			19: begin k.text = PREFIX_BITS'("ROL"); k.len = 4'd3; end
			20: begin k.text = PREFIX_BITS'("ROR"); k.len = 4'd3; end
			21: begin k.text = PREFIX_BITS'("SHL"); k.len = 4'd3; end
			22: begin k.text = PREFIX_BITS'("SHR"); k.len = 4'd3; end
			23: begin k.text = PREFIX_BITS'("JEQ"); k.len = 4'd3; end
			24: begin k.text = PREFIX_BITS'("JNE"); k.len = 4'd3; end
			25: begin k.text = PREFIX_BITS'("JLT"); k.len = 4'd3; end
			26: begin k.text = PREFIX_BITS'("JGT"); k.len = 4'd3; end
			27: begin k.text = PREFIX_BITS'("JLE"); k.len = 4'd3; end
			28: begin k.text = PREFIX_BITS'("JGE"); k.len = 4'd3; end
			29: begin k.text = PREFIX_BITS'("JMP"); k.len = 4'd3; end
			30: begin k.text = PREFIX_BITS'("SWI"); k.len = 4'd3; end
			31: begin k.text = PREFIX_BITS'("CALL"); k.len = 4'd4; end
			32: begin k.text = PREFIX_BITS'("RET"); k.len = 4'd3; end
			33: begin k.text = PREFIX_BITS'("IRET"); k.len = 4'd4; end
			34: begin k.text = PREFIX_BITS'("PUSH"); k.len = 4'd4; end
			35: begin k.text = PREFIX_BITS'("POP"); k.len = 4'd3; end
			36: begin k.text = PREFIX_BITS'("PUSHB"); k.len = 4'd5; end
			37: begin k.text = PREFIX_BITS'("POPB"); k.len = 4'd4; end
			38: begin k.text = PREFIX_BITS'("RESW"); k.len = 4'd4; end
			39: begin k.text = PREFIX_BITS'("RESB"); k.len = 4'd4; end
			40: begin k.text = PREFIX_BITS'("WORD"); k.len = 4'd4; end
			41: begin k.text = PREFIX_BITS'("BYTE"); k.len = 4'd4; end
			default: begin k.len = 4'd0; end
		endcase
		return k;
	endfunction

endpackage

// File: hdl/ats_front.sv
// scanner state machine: takes one byte per beat, produces up to two tokens
module ats_front import ats_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              source_byte,
	input  logic                    end_of_input,
	input  logic                    cfg_valid,
	input  logic [15:0]             cfg_data,
	input  logic                    room,
	output logic                    push,
	output logic [1:0]              push_count,
	output token_t                  tok_a,
	output token_t                  tok_b
);

	localparam logic [ROW_BITS-1:0] ROW_MAX = '1;
	localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	mode_t mode_q, mode_d;
	logic [31:0] acc_q, acc_d;
	logic [PREFIX_BITS-1:0] prefix_q, prefix_d;
	logic [LEN_BITS-1:0] plen_q, plen_d;
	logic [OFFSET_BITS-1:0] pstart_q, pstart_d;
	logic [ROW_BITS-1:0] prow_q, prow_d;
	logic [COLUMN_BITS-1:0] pcol_q, pcol_d;
	logic [ROW_BITS-1:0] line_q, line_d;
	logic [COLUMN_BITS-1:0] colcnt_q, colcnt_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic fin_q, fin_d;

	logic [COLUMN_BITS-1:0] col;
	logic [OFFSET_BITS-1:0] pos_inc;
	logic [LEN_BITS-1:0] plen_inc;
	logic is_digit, is_letter, is_blank;
	logic [5:0] wkind;
	logic [ROW_BITS-1:0] cfg_row;
	logic fire;

	assign in_ready = room;
	assign fire = in_valid & room;
	assign col = (colcnt_q == COL_MAX) ? COL_MAX : colcnt_q + 1'b1;
	assign pos_inc = (pos_q == OFF_MAX) ? OFF_MAX : pos_q + 1'b1;
	assign plen_inc = (plen_q == LEN_MAX) ? LEN_MAX : plen_q + 1'b1;
	assign is_digit = source_byte >= "0" && source_byte <= "9";
	assign is_letter = (source_byte >= "a" && source_byte <= "z")
		|| (source_byte >= "A" && source_byte <= "Z") || source_byte == "_";
	assign is_blank = source_byte == " " || source_byte == 8'd9
		|| source_byte == 8'd13 || source_byte == 8'd10;
	assign cfg_row = ROW_BITS'(cfg_data);

	always_comb begin
		wkind = KIND_IDENT;
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			if (plen_q <= LEN_BITS'(KEYWORD_MAX_LEN)
				&& LEN_BITS'(kw_entry(i).len) == plen_q && kw_entry(i).text == prefix_q)
				wkind = KIND_KEYWORD0 + 6'(i);
		end
	end

	function automatic token_t mk(input logic [5:0] k, input logic [ROW_BITS-1:0] r,
		input logic [COLUMN_BITS-1:0] c, input logic [OFFSET_BITS-1:0] o,
		input logic [LEN_BITS-1:0] l, input logic [31:0] n, input logic [7:0] b);
		token_t t;
		t.kind = k; t.row = r; t.column = c; t.offset = o;
		t.length = l; t.number = n; t.bad = b; t.last = 1'b0;
		return t;
	endfunction

	always_comb begin
		logic consumed;
		logic [1:0] n;
		token_t t0, t1, te;
		consumed = 1'b0;
		n = 2'd0;
		t0 = '0;
		t1 = '0;
		te = '0;
		mode_d = mode_q; acc_d = acc_q; prefix_d = prefix_q; plen_d = plen_q;
		pstart_d = pstart_q; prow_d = prow_q; pcol_d = pcol_q; line_d = line_q;
		colcnt_d = colcnt_q; pos_d = pos_q; fin_d = fin_q;
		if (fin_q) begin
			t0 = mk(KIND_EOF, line_q, col, pos_q, '0, '0, '0);
			n = 2'd1;
		end else if (end_of_input) begin
			te = mk(KIND_EOF, line_q, col, pos_q, '0, '0, '0);
			case (mode_q)
				MODE_NUMBER: begin t0 = mk(KIND_NUMBER, prow_q, pcol_q, pstart_q, plen_q, acc_q, '0); n = 2'd1; end
				MODE_WORD: begin t0 = mk(wkind, prow_q, pcol_q, pstart_q, plen_q, '0, '0); n = 2'd1; end
				MODE_STRING: begin t0 = mk(KIND_UNCLOSED, prow_q, pcol_q, pstart_q, plen_q, '0, '0); n = 2'd1; end
				default: n = 2'd0;
			endcase
			if (n == 2'd1) begin
				t1 = te;
				n = 2'd2;
			end else begin
				t0 = te;
				n = 2'd1;
			end
			mode_d = MODE_IDLE;
			fin_d = 1'b1;
		end else begin
			case (mode_q)
				MODE_NUMBER: begin
					if (is_digit) begin
						acc_d = 32'((acc_q << 3) + (acc_q << 1) + 32'(source_byte - "0"));
						plen_d = plen_inc;
						consumed = 1'b1;
					end else begin
						t0 = mk(KIND_NUMBER, prow_q, pcol_q, pstart_q, plen_q, acc_q, '0);
						n = 2'd1;
						mode_d = MODE_IDLE;
					end
				end
				MODE_WORD: begin
					if (is_letter || is_digit) begin
						if (plen_q < LEN_BITS'(KEYWORD_MAX_LEN))
							prefix_d = {prefix_q[PREFIX_BITS-9:0], source_byte};
						plen_d = plen_inc;
						consumed = 1'b1;
					end else begin
						t0 = mk(wkind, prow_q, pcol_q, pstart_q, plen_q, '0, '0);
						n = 2'd1;
						mode_d = MODE_IDLE;
					end
				end
				MODE_STRING: begin
					if (source_byte == "\"") begin
						t0 = mk(KIND_STRING, prow_q, pcol_q, pstart_q, plen_q, '0, '0);
						n = 2'd1;
						mode_d = MODE_IDLE;
					end else begin
						plen_d = plen_inc;
					end
					consumed = 1'b1;
				end
				MODE_COMMENT: begin
					if (source_byte != 8'd10) consumed = 1'b1;
					else mode_d = MODE_IDLE;
				end
				default: mode_d = MODE_IDLE;
			endcase
			if (!consumed) begin
				te = '0;
				if (is_blank) begin
					te = '0;
				end else if (source_byte == ";") begin
					mode_d = MODE_COMMENT;
				end else if (source_byte == "\"") begin
					mode_d = MODE_STRING;
					pstart_d = pos_inc; prow_d = line_q; pcol_d = col; plen_d = '0;
				end else if (is_digit) begin
					mode_d = MODE_NUMBER;
					acc_d = 32'(source_byte - "0");
					pstart_d = pos_q; prow_d = line_q; pcol_d = col; plen_d = LEN_BITS'(1);
				end else if (is_letter) begin
					mode_d = MODE_WORD;
					prefix_d = PREFIX_BITS'(source_byte);
					pstart_d = pos_q; prow_d = line_q; pcol_d = col; plen_d = LEN_BITS'(1);
				end else begin
					if (source_byte == ",")
						te = mk(KIND_COMMA, line_q, col, pos_q, LEN_BITS'(1), '0, '0);
					else if (source_byte == ":")
						te = mk(KIND_COLON, line_q, col, pos_q, LEN_BITS'(1), '0, '0);
					else
						te = mk(KIND_BAD, line_q, col, pos_q, LEN_BITS'(1), '0, source_byte);
					if (n == 2'd0) t0 = te;
					else t1 = te;
					n = n + 2'd1;
				end
			end
			if (source_byte == 8'd10) begin
				line_d = (line_q == ROW_MAX) ? ROW_MAX : line_q + 1'b1;
				colcnt_d = '0;
			end else begin
				colcnt_d = col;
			end
			pos_d = pos_inc;
		end
		if (n == 2'd1) t0.last = 1'b1;
		if (n == 2'd2) t1.last = 1'b1;
		push_count = n;
		tok_a = t0;
		tok_b = t1;
	end

	assign push = fire && push_count != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q <= '0; prefix_q <= '0; plen_q <= '0; pstart_q <= '0;
			prow_q <= '0; pcol_q <= '0; line_q <= ROW_BITS'(1);
			colcnt_q <= '0; pos_q <= '0; fin_q <= 1'b0;
		end else begin
			if (fire) begin
				mode_q <= mode_d; acc_q <= acc_d; prefix_q <= prefix_d; plen_q <= plen_d;
				pstart_q <= pstart_d; prow_q <= prow_d; pcol_q <= pcol_d;
				line_q <= line_d; colcnt_q <= colcnt_d; pos_q <= pos_d; fin_q <= fin_d;
			end else if (cfg_valid && pos_q == '0 && !fin_q) begin
				line_q <= cfg_row;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> mode_q == MODE_IDLE) else $error("mode not idle after eof");
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_of_input && !fin_q |=> fin_q) else $error("eof not latched");
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_count == 2'd1 ? tok_a.last : tok_b.last && !tok_a.last))
		else $error("last flag misplaced");

endmodule

// File: hdl/ats_queue.sv
// token queue; takes up to two tokens a beat, hands out one
module ats_queue import ats_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  logic [1:0] push_count,
	input  token_t tok_a,
	input  token_t tok_b,
	output logic   room,
	output logic   out_valid,
	input  logic   out_ready,
	output token_t head
);

	token_t mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] rd_q, wr_q;
	logic [QPTR_BITS:0] cnt_q;
	logic pop;

	assign out_valid = cnt_q != '0;
	assign pop = out_valid & out_ready;
	assign head = mem_q[rd_q];
	// two free slots covers the worst beat, independent of a pop
	assign room = cnt_q <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= tok_a;
			if (push_count == 2'd2) mem_q[wr_q + 1'b1] <= tok_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			if (pop) rd_q <= rd_q + 1'b1;
			if (push) wr_q <= wr_q + QPTR_BITS'(push_count);
			cnt_q <= cnt_q + (push ? (QPTR_BITS+1)'(push_count) : '0)
				- (QPTR_BITS+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_BITS+1)'(QUEUE_DEPTH)) else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room) else $error("push without room");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1) else $error("count slip");

endmodule

// File: hdl/assembly_token_scanner.sv
// assembly token scanner
// in channel: in_valid/in_ready carry one source beat (source_byte, end_of_input).
//   a beat with end_of_input flushes a pending token and then yields eof;
//   every beat after that yields one more eof until reset.
// out channel: out_valid/out_ready carry one token beat; last_of_run marks the
//   final token caused by an input beat (each beat causes zero to two tokens).
// cfg channel: cfg_valid/cfg_ready write first_row; before the first byte it
//   also sets the current row. write only while the block is idle.
// a token enters the queue when its ending byte is taken. the scanner takes one
//   byte per cycle while the queue has room; its state is registered per byte.
//   the 4-entry queue accepts a byte whenever two slots are free, so a stalled
//   receiver stops input only once the queue holds more than two tokens; a
//   steady two-token pattern drains one token per cycle while out_ready is high.
// reset: row = 1, column and offset 0, queue empty; first_row reg unused
//   beyond the initial row load, so no register is kept for it.
module assembly_token_scanner import ats_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             source_byte,
	input  logic                   end_of_input,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [15:0]            cfg_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [5:0]             token_kind,
	output logic [ROW_BITS-1:0]    token_row,
	output logic [COLUMN_BITS-1:0] token_column,
	output logic [OFFSET_BITS-1:0] start_offset,
	output logic [LEN_BITS-1:0]    token_length,
	output logic [31:0]            number_value,
	output logic [7:0]             bad_byte,
	output logic                   last_of_run
);

	logic room, push;
	logic [1:0] push_count;
	token_t tok_a, tok_b, head;

	// config writes are always accepted
	assign cfg_ready = 1'b1;

	ats_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .source_byte, .end_of_input,
		.cfg_valid, .cfg_data, .room, .push, .push_count, .tok_a, .tok_b
	);

	ats_queue u_queue (
		.clk, .arst_n, .push, .push_count, .tok_a, .tok_b, .room,
		.out_valid, .out_ready, .head
	);

	assign token_kind = head.kind;
	assign token_row = head.row;
	assign token_column = head.column;
	assign start_offset = head.offset;
	assign token_length = head.length;
	assign number_value = head.number;
	assign bad_byte = head.bad;
	assign last_of_run = head.last;

endmodule

// File: dv/assembly_token_scanner_tb.sv
module assembly_token_scanner_tb import ats_pkg::*; ();

	// row given to the first source line in the directed part
	localparam logic [15:0] START_ROW = 16'hFFFC;
	localparam int RANDOM_BEATS = 930;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] source_byte = 8'd0;
	logic end_of_input = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = 16'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] token_kind;
	logic [ROW_BITS-1:0] token_row;
	logic [COLUMN_BITS-1:0] token_column;
	logic [OFFSET_BITS-1:0] start_offset;
	logic [LEN_BITS-1:0] token_length;
	logic [31:0] number_value;
	logic [7:0] bad_byte;
	logic last_of_run;

	assembly_token_scanner dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.source_byte(source_byte), .end_of_input(end_of_input),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .token_row(token_row), .token_column(token_column),
		.start_offset(start_offset), .token_length(token_length),
		.number_value(number_value), .bad_byte(bad_byte), .last_of_run(last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// keyword spellings in kind order, starting at KIND_KEYWORD0
	string kw_names[NUM_KEYWORDS] = '{
		"LD", "ST", "LDB", "STB", "LDR", "STR", "LBR", "SBR", "LDI", "CMP",
		"MOV", "ADD", "SUB", "MUL", "DIV", "AND", "OR", "XOR", "ADDI", "ROL",
		"ROR", "SHL", "SHR", "JEQ", "JNE", "JLT", "JGT", "JLE", "JGE", "JMP",
		"SWI", "CALL", "RET", "IRET", "PUSH", "POP", "PUSHB", "POPB", "RESW",
		"RESB", "WORD", "BYTE"
	};

	// scanner mirror state
	mode_t lex_mode = MODE_IDLE;
	logic [31:0] num_acc = '0;
	logic [PREFIX_BITS-1:0] word_bits = '0;
	logic [15:0] tok_len = '0;
	logic [OFFSET_BITS-1:0] tok_start = '0;
	logic [ROW_BITS-1:0] tok_row = '0;
	logic [COLUMN_BITS-1:0] tok_col = '0;
	logic [ROW_BITS-1:0] cur_row = 16'd1;
	logic [COLUMN_BITS-1:0] cur_col = '0;
	logic [OFFSET_BITS-1:0] cur_pos = '0;
	bit saw_eof = 0;

	token_t tokens_due[$];
	logic [7:0] text_q[$];
	int errors = 0;
	int rx_wait = 0;
	bit no_idle = 0;

	function automatic logic [15:0] inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] inc_off(input logic [OFFSET_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic bit is_num(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	// identifier or keyword, from the first letters and the length
	function automatic logic [5:0] classify_word();
		logic [PREFIX_BITS-1:0] packed_kw;
		string s;
		if (tok_len > KEYWORD_MAX_LEN) return KIND_IDENT;
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			s = kw_names[i];
			packed_kw = '0;
			for (int j = 0; j < s.len(); j++) packed_kw = {packed_kw[PREFIX_BITS-9:0], s[j]};
			if (s.len() == tok_len && packed_kw == word_bits) return KIND_KEYWORD0 + 6'(i);
		end
		return KIND_IDENT;
	endfunction

	function automatic void push_token(input logic [5:0] kind, input logic [15:0] row,
			input logic [15:0] col, input logic [OFFSET_BITS-1:0] off, input logic [15:0] len,
			input logic [31:0] num, input logic [7:0] bad);
		token_t t;
		t.kind = kind; t.row = row; t.column = col; t.offset = off;
		t.length = len; t.number = num; t.bad = bad; t.last = 1'b0;
		tokens_due.push_back(t);
	endfunction

	function automatic void push_held(input logic [5:0] kind, input logic [31:0] num);
		push_token(kind, tok_row, tok_col, tok_start, tok_len, num, 8'd0);
	endfunction

	function automatic void hold_token(input logic [OFFSET_BITS-1:0] off,
			input logic [15:0] col, input logic [15:0] len);
		tok_start = off; tok_row = cur_row; tok_col = col; tok_len = len;
	endfunction

	// advance the mirror by one source beat and queue the tokens it yields
	function automatic void scan_beat(input logic [7:0] b, input bit eoi);
		logic [OFFSET_BITS-1:0] p;
		logic [15:0] c;
		bit took;
		int n0;
		p = cur_pos;
		c = inc16(cur_col);
		took = 0;
		n0 = tokens_due.size();
		if (saw_eof) begin
			push_token(KIND_EOF, cur_row, c, p, 16'd0, 32'd0, 8'd0);
		end else if (eoi) begin
			case (lex_mode)
				MODE_NUMBER: push_held(KIND_NUMBER, num_acc);
				MODE_WORD: push_held(classify_word(), 32'd0);
				MODE_STRING: push_held(KIND_UNCLOSED, 32'd0);
				default: ;
			endcase
			lex_mode = MODE_IDLE;
			push_token(KIND_EOF, cur_row, c, p, 16'd0, 32'd0, 8'd0);
			saw_eof = 1;
		end else begin
			case (lex_mode)
				MODE_NUMBER: begin
					if (is_num(b)) begin
						num_acc = num_acc * 32'd10 + 32'(b - "0");
						tok_len = inc16(tok_len);
						took = 1;
					end else begin
						push_held(KIND_NUMBER, num_acc);
						lex_mode = MODE_IDLE;
					end
				end
				MODE_WORD: begin
					if (is_alpha(b) || is_num(b)) begin
						if (tok_len < KEYWORD_MAX_LEN) word_bits = {word_bits[PREFIX_BITS-9:0], b};
						tok_len = inc16(tok_len);
						took = 1;
					end else begin
						push_held(classify_word(), 32'd0);
						lex_mode = MODE_IDLE;
					end
				end
				MODE_STRING: begin
					if (b == "\"") begin
						push_held(KIND_STRING, 32'd0);
						lex_mode = MODE_IDLE;
					end else begin
						tok_len = inc16(tok_len);
					end
					took = 1;
				end
				MODE_COMMENT: begin
					// the newline that ends a comment is scanned as a blank
					if (b != 8'd10) took = 1;
					else lex_mode = MODE_IDLE;
				end
				default: lex_mode = MODE_IDLE;
			endcase
			if (!took) begin
				if (b == " " || b == 8'd9 || b == 8'd13 || b == 8'd10) begin
				end else if (b == ";") begin
					lex_mode = MODE_COMMENT;
				end else if (b == "\"") begin
					lex_mode = MODE_STRING;
					hold_token(inc_off(p), c, 16'd0);
				end else if (is_num(b)) begin
					lex_mode = MODE_NUMBER;
					num_acc = 32'(b - "0");
					hold_token(p, c, 16'd1);
				end else if (is_alpha(b)) begin
					lex_mode = MODE_WORD;
					word_bits = PREFIX_BITS'(b);
					hold_token(p, c, 16'd1);
				end else if (b == ",") begin
					push_token(KIND_COMMA, cur_row, c, p, 16'd1, 32'd0, 8'd0);
				end else if (b == ":") begin
					push_token(KIND_COLON, cur_row, c, p, 16'd1, 32'd0, 8'd0);
				end else begin
					push_token(KIND_BAD, cur_row, c, p, 16'd1, 32'd0, b);
				end
			end
			if (b == 8'd10) begin
				cur_row = inc16(cur_row);
				cur_col = '0;
			end else begin
				cur_col = inc16(cur_col);
			end
			cur_pos = inc_off(cur_pos);
		end
		if (tokens_due.size() > n0) tokens_due[tokens_due.size()-1].last = 1'b1;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 9);
	endfunction

	// one source beat; valid stays up across back-to-back beats
	task automatic send_beat(input logic [7:0] b, input bit eoi);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		source_byte <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		scan_beat(b, eoi);
	endtask

	// drop input valid and wait until every queued token has drained
	task automatic drain();
		in_valid <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// valid stays up so writes can follow back to back; the caller drops it
	task automatic write_first_row(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (cur_pos == 0 && !saw_eof) cur_row = v;
	endtask

	// random source fragments, mostly well formed
	function automatic void add_fragment();
		int pick;
		int n;
		string s;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			s = kw_names[$urandom_range(0, NUM_KEYWORDS-1)];
			n = $urandom_range(0, 3);
			for (int i = 0; i < s.len(); i++)
				// occasionally lower-case a letter so the match must fail
				text_q.push_back((n == 0 && i == 0) ? (s[i] | 8'h20) : s[i]);
		end else if (pick < 35) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 3))
					0: text_q.push_back(8'($urandom_range("A", "Z")));
					1: text_q.push_back(8'($urandom_range("a", "z")));
					2: text_q.push_back(i == 0 ? "_" : 8'($urandom_range("0", "9")));
					default: text_q.push_back("_");
				endcase
			end
		end else if (pick < 50) begin
			// up to twelve digits, so the value wraps now and then
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range("0", "9")));
		end else if (pick < 58) begin
			text_q.push_back("\"");
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++)
				text_q.push_back(($urandom_range(0, 7) == 0) ? 8'd10 : 8'($urandom_range(" ", "!")));
			text_q.push_back("\"");
		end else if (pick < 63) begin
			text_q.push_back(";");
			n = $urandom_range(0, 5);
			for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(32, 126)));
			text_q.push_back(8'd10);
		end else if (pick < 88) begin
			case ($urandom_range(0, 5))
				0: text_q.push_back(" ");
				1: text_q.push_back(8'd9);
				2: text_q.push_back(",");
				3: text_q.push_back(":");
				4: text_q.push_back(8'd10);
				default: text_q.push_back(8'd13);
			endcase
		end else begin
			// noise: any byte at all
			text_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	typedef struct {
		logic [7:0] b;
		bit eoi;
		bit typed;
		token_t want;
	} dir_row_t;

	dir_row_t dir_tab[22];

	initial begin
		int sent;
		int tail;
		dir_tab = '{
			'{8'h2C, 1'b0, 1'b1, '{KIND_COMMA, START_ROW, 16'd1, 24'd0, 16'd1, 32'd0, 8'd0, 1'b1}},
			'{8'h00, 1'b0, 1'b1, '{KIND_BAD, START_ROW, 16'd2, 24'd1, 16'd1, 32'd0, 8'h00, 1'b1}},
			'{8'hFF, 1'b0, 1'b1, '{KIND_BAD, START_ROW, 16'd3, 24'd2, 16'd1, 32'd0, 8'hFF, 1'b1}},
			'{8'h3A, 1'b0, 1'b1, '{KIND_COLON, START_ROW, 16'd4, 24'd3, 16'd1, 32'd0, 8'd0, 1'b1}},
			'{8'd10, 1'b0, 1'b0, '0},
			'{"P", 1'b0, 1'b0, '0}, '{"U", 1'b0, 1'b0, '0}, '{"S", 1'b0, 1'b0, '0},
			'{"H", 1'b0, 1'b0, '0}, '{"B", 1'b0, 1'b0, '0},
			'{";", 1'b0, 1'b0, '0}, '{"x", 1'b0, 1'b0, '0}, '{8'd10, 1'b0, 1'b0, '0},
			// string across a newline
			'{"\"", 1'b0, 1'b0, '0}, '{"a", 1'b0, 1'b0, '0}, '{8'd10, 1'b0, 1'b0, '0},
			'{"\"", 1'b0, 1'b0, '0},
			'{"0", 1'b0, 1'b0, '0}, '{"9", 1'b0, 1'b0, '0}, '{"z", 1'b0, 1'b0, '0},
			'{8'd9, 1'b0, 1'b0, '0}, '{8'd13, 1'b0, 1'b0, '0}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register extremes before any byte, the last one sets the start row
		write_first_row(16'hFFFF);
		write_first_row(16'h0000);
		write_first_row(16'($urandom_range(0, 65535)));
		write_first_row(START_ROW);
		cfg_valid <= 1'b0;

		foreach (dir_tab[i]) begin
			send_beat(dir_tab[i].b, dir_tab[i].eoi);
			if (dir_tab[i].typed) tokens_due[tokens_due.size()-1] = dir_tab[i].want;
		end

		sent = 0;
		while (sent < RANDOM_BEATS) begin
			if (text_q.size() == 0) add_fragment();
			no_idle = (sent >= 150 && sent < 250);
			if (sent == 300 || sent == 600) begin
				// sender holds off until every queued token has drained
				drain();
				write_first_row(sent == 300 ? 16'h0000 : 16'hFFFF);
				cfg_valid <= 1'b0;
			end
			send_beat(text_q.pop_front(), 1'b0);
			sent++;
		end

		// leave something open at the end of input
		case ($urandom_range(0, 3))
			0: begin send_beat("\"", 1'b0); send_beat("q", 1'b0); end
			1: begin send_beat(";", 1'b0); send_beat("q", 1'b0); end
			2: send_beat("7", 1'b0);
			default: send_beat("R", 1'b0);
		endcase
		send_beat(8'($urandom_range(0, 255)), 1'b1);
		// beats after eof keep yielding eof
		for (tail = 0; tail < 3; tail++) send_beat(8'($urandom_range(0, 255)), tail[0]);
		in_valid <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// token receiver with random stalls
	always @(posedge clk) begin
		token_t want;
		if (out_valid && out_ready) begin
			if (tokens_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected token beat kind %0d", token_kind);
			end else begin
				want = tokens_due.pop_front();
				if (token_kind !== want.kind || token_row !== want.row
						|| token_column !== want.column || start_offset !== want.offset
						|| token_length !== want.length || number_value !== want.number
						|| bad_byte !== want.bad || last_of_run !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("token mismatch: want k%0d r%0d c%0d o%0d l%0d n%0d b%0d e%0d, got k%0d r%0d c%0d o%0d l%0d n%0d b%0d e%0d",
							want.kind, want.row, want.column, want.offset, want.length,
							want.number, want.bad, want.last, token_kind, token_row,
							token_column, start_offset, token_length, number_value,
							bad_byte, last_of_run);
				end
			end
			rx_wait = draw_gap();
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		out_ready <= (rx_wait == 0) && arst_n;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
